// ----- src/ptba_pkg.sv -----
`default_nettype none
package ptba_pkg;
  localparam int Entries = 64;
  localparam int IdxBits = $clog2(Entries);
  localparam int CntBits = $clog2(Entries + 1);
  localparam int KeyBits = 32;
  localparam int TimeBits = 48;
  localparam int QtyBits = 20;
  localparam int PriceBits = 20;
  localparam int VolBits = 40;
  localparam int NotBits = 60;
  localparam int QDepth = 2;

  typedef struct packed {
    logic [KeyBits-1:0]   key;
    logic [TimeBits-1:0]  t;
    logic [QtyBits-1:0]   qty;
    logic [PriceBits-1:0] price;
  } trade_t;

  typedef struct packed {
    logic                 full;
    logic                 fresh;
    logic [TimeBits-1:0]  gap;
    logic [VolBits-1:0]   vol;
    logic [NotBits-1:0]   notional;
    logic [PriceBits-1:0] high;
  } job_t;
endpackage
`default_nettype wire

// ----- src/ptba_front.sv -----
`default_nettype none
module ptba_front
  import ptba_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  output logic        busy,
  input  wire trade_t trade,
  input  wire logic   q_ready,
  output logic        q_push,
  output job_t        q_data
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_RD = 5'b00100, S_UPD = 5'b01000,
    S_PUSH = 5'b10000
  } st_t;

  st_t                  st_r, st_nxt;
  trade_t               tr_r;
  logic [IdxBits:0]     idx_r;
  logic [IdxBits-1:0]   hit_r;
  logic                 found_r;
  logic [CntBits-1:0]   used_r;
  logic [Entries-1:0]   valid_r;
  job_t                 job_r;

  logic [KeyBits-1:0]   key_m [Entries];
  logic [TimeBits-1:0]  time_m [Entries];
  logic [TimeBits-1:0]  gap_m [Entries];
  logic [VolBits-1:0]   vol_m [Entries];
  logic [NotBits-1:0]   not_m [Entries];
  logic [PriceBits-1:0] high_m [Entries];

  logic [KeyBits-1:0]   key_rd_r;
  logic                 rd_ok_r;
  logic [IdxBits-1:0]   rd_idx_r;
  logic [TimeBits-1:0]  time_rd_r, gap_rd_r;
  logic [VolBits-1:0]   vol_rd_r;
  logic [NotBits-1:0]   not_rd_r;
  logic [PriceBits-1:0] high_rd_r;
  logic [TimeBits-1:0]  d, gap_n;
  logic [VolBits-1:0]   vol_n;
  logic [NotBits-1:0]   not_n, prod;
  logic [PriceBits-1:0] high_n;
  logic [VolBits:0]     vsum;
  logic [NotBits:0]     nsum;
  logic [QtyBits+PriceBits-1:0] prod_w;
  logic [IdxBits-1:0]   widx;

  assign busy = (st_r != S_IDLE);
  assign q_push = (st_r == S_PUSH) && q_ready;
  assign q_data = job_r;

  always_ff @(posedge clk) begin
    key_rd_r <= key_m[idx_r[IdxBits-1:0]];
    rd_idx_r <= idx_r[IdxBits-1:0];
    rd_ok_r  <= (st_r == S_SCAN) && (idx_r < (IdxBits+1)'(Entries))
                && (idx_r < (IdxBits+1)'(used_r));
  end

  // entry fields of the hit, registered from hit_r; they hold the hit's fields in S_UPD
  always_ff @(posedge clk) begin
    time_rd_r <= time_m[hit_r];
    gap_rd_r  <= gap_m[hit_r];
    vol_rd_r  <= vol_m[hit_r];
    not_rd_r  <= not_m[hit_r];
    high_rd_r <= high_m[hit_r];
  end

  assign prod_w  = tr_r.price * tr_r.qty;
  assign prod    = NotBits'(prod_w);
  assign d       = (tr_r.t >= time_rd_r) ? tr_r.t - time_rd_r : '0;
  assign gap_n   = (d > gap_rd_r) ? d : gap_rd_r;
  assign high_n  = (tr_r.price > high_rd_r) ? tr_r.price : high_rd_r;
  assign vsum    = {1'b0, vol_rd_r} + (VolBits+1)'(tr_r.qty);
  assign vol_n   = vsum[VolBits] ? '1 : vsum[VolBits-1:0];
  assign nsum    = {1'b0, not_rd_r} + {1'b0, prod};
  assign not_n   = nsum[NotBits] ? '1 : nsum[NotBits-1:0];
  assign widx    = found_r ? hit_r : used_r[IdxBits-1:0];

  always_ff @(posedge clk) begin
    if (st_r == S_UPD && (found_r || used_r < CntBits'(Entries))) begin
      key_m[widx]  <= tr_r.key;
      time_m[widx] <= tr_r.t;
      gap_m[widx]  <= found_r ? gap_n : '0;
      vol_m[widx]  <= found_r ? vol_n : VolBits'(tr_r.qty);
      not_m[widx]  <= found_r ? not_n : prod;
      high_m[widx] <= found_r ? high_n : tr_r.price;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_SCAN;
      S_SCAN: if ((rd_ok_r && key_rd_r == tr_r.key) ||
                  idx_r > (IdxBits+1)'(Entries)) st_nxt = S_RD;
      S_RD:   st_nxt = S_UPD;
      S_UPD:  st_nxt = S_PUSH;
      S_PUSH: if (q_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      valid_r <= '0;
      found_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: begin
          tr_r <= trade;
          idx_r <= '0;
          found_r <= 1'b0;
        end
        S_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (rd_ok_r && key_rd_r == tr_r.key && valid_r[rd_idx_r]) begin
            found_r <= 1'b1;
            hit_r <= rd_idx_r;
          end
        end
        S_RD: ;
        S_UPD: begin
          job_r.full <= !found_r && used_r >= CntBits'(Entries);
          job_r.fresh <= !found_r && used_r < CntBits'(Entries);
          if (found_r) begin
            job_r.gap <= gap_n; job_r.vol <= vol_n;
            job_r.notional <= not_n; job_r.high <= high_n;
          end else if (used_r < CntBits'(Entries)) begin
            job_r.gap <= '0; job_r.vol <= VolBits'(tr_r.qty);
            job_r.notional <= prod; job_r.high <= tr_r.price;
            valid_r[used_r[IdxBits-1:0]] <= 1'b1;
            used_r <= used_r + 1'b1;
          end else begin
            job_r.gap <= '0; job_r.vol <= '0;
            job_r.notional <= '0; job_r.high <= '0;
          end
        end
        S_PUSH: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/ptba_queue.sv -----
`default_nettype none
module ptba_queue
  import ptba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t din,
  output logic      ready,
  input  wire logic pop,
  output logic      nonempty,
  output job_t      dout
);
  localparam int PB = $clog2(QDepth);
  job_t          mem_r [QDepth];
  logic [PB-1:0] wp_r, rp_r;
  logic [PB:0]   cnt_r;

  assign ready = cnt_r < (PB+1)'(QDepth);
  assign nonempty = cnt_r != '0;
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PB+1)'(push) - (PB+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- src/ptba_back.sv -----
`default_nettype none
module ptba_back
  import ptba_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_nonempty,
  input  wire job_t            q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic                 out_table_full,
  output logic                 out_is_new_symbol,
  output logic [TimeBits-1:0]  out_largest_gap,
  output logic [VolBits-1:0]   out_total_volume,
  output logic [PriceBits-1:0] out_average_price,
  output logic [PriceBits-1:0] out_highest_price
);
  localparam int CB = $clog2(NotBits + 1);
  job_t               job_r;
  logic               run_r, fin_r;
  logic [CB-1:0]      cnt_r;
  logic [NotBits-1:0] q_r;
  logic [VolBits:0]   rem_r;
  logic [VolBits:0]   sh, rem2;
  logic               ge;
  logic [NotBits:0]   qround;

  assign q_pop = q_nonempty && !run_r && !fin_r;
  assign sh = {rem_r[VolBits-1:0], q_r[NotBits-1]};
  assign ge = sh >= {1'b0, job_r.vol};
  assign rem2 = rem_r << 1;
  assign qround = {1'b0, q_r} +
    (NotBits+1)'(rem2 >= {1'b0, job_r.vol});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; fin_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (q_pop) begin
        job_r <= q_data;
        q_r <= q_data.notional;
        rem_r <= '0;
        cnt_r <= CB'(NotBits);
        run_r <= 1'b1;
      end else if (run_r) begin
        q_r <= {q_r[NotBits-2:0], ge};
        rem_r <= ge ? sh - {1'b0, job_r.vol} : sh;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CB'(1)) begin
          run_r <= 1'b0; fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r <= 1'b0;
        out_valid <= 1'b1;
        out_table_full <= job_r.full;
        out_is_new_symbol <= job_r.fresh;
        out_largest_gap <= job_r.gap;
        out_total_volume <= job_r.vol;
        out_highest_price <= job_r.high;
        if (job_r.vol == '0) out_average_price <= '0;
        else if (qround > (NotBits+1)'({PriceBits{1'b1}})) out_average_price <= '1;
        else out_average_price <= qround[PriceBits-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/per_symbol_trade_bar_aggregator_top.sv -----
// the front scans the 64-entry table one entry per cycle, stopping early on a hit and
// running to the end of the table on a miss; the back runs a 60-step divider
// the queue between them lets the front take the next trade while the back is
// still dividing, as long as the queue has room
// out_valid is a one-cycle strobe; the receiver cannot stall
// synchronous active-low reset empties the table and the queue
`default_nettype none
module per_symbol_trade_bar_aggregator_top
  import ptba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KeyBits-1:0]   in_symbol_key,
  input  wire logic [TimeBits-1:0]  in_trade_time,
  input  wire logic [QtyBits-1:0]   in_trade_quantity,
  input  wire logic [PriceBits-1:0] in_trade_price,
  output logic                      out_valid,
  output logic                      out_table_full,
  output logic                      out_is_new_symbol,
  output logic [TimeBits-1:0]       out_largest_gap,
  output logic [VolBits-1:0]        out_total_volume,
  output logic [PriceBits-1:0]      out_average_price,
  output logic [PriceBits-1:0]      out_highest_price
);
  trade_t tr;
  job_t   pj, qj;
  logic   qrdy, qpush, qne, qpop;

  assign tr = '{key: in_symbol_key, t: in_trade_time,
                qty: in_trade_quantity, price: in_trade_price};

  ptba_front u_front (.clk, .rst_n, .start, .busy, .trade(tr),
    .q_ready(qrdy), .q_push(qpush), .q_data(pj));
  ptba_queue u_queue (.clk, .rst_n, .push(qpush), .din(pj), .ready(qrdy),
    .pop(qpop), .nonempty(qne), .dout(qj));
  ptba_back u_back (.clk, .rst_n, .q_nonempty(qne), .q_data(qj), .q_pop(qpop),
    .out_valid, .out_table_full, .out_is_new_symbol, .out_largest_gap,
    .out_total_volume, .out_average_price, .out_highest_price);
endmodule
`default_nettype wire
